### rtl/lav_pkg.sv
// Shared widths, command codes, control structs and arithmetic helpers of the look-at block.
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int FIELD_W   = 32;
  localparam int OUT_W     = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int VEC_W     = FRAC_BITS + 3;   // unit vector component, signed
  localparam int NRM_W     = FRAC_BITS + 32;  // magnitude under normalization
  localparam int QB        = FRAC_BITS + 2;   // quotient bits of one division
  localparam int DIVN_W    = FRAC_BITS + 32;  // dividend width
  localparam int REM_W     = 34;
  localparam int QCNT_W    = $clog2(QB);
  localparam int MUL_W     = 32;
  localparam int ACC_W     = 64;

  // normalization register operations
  localparam logic [2:0] NRM_NONE  = 3'd0;
  localparam logic [2:0] NRM_LD_D  = 3'd1;
  localparam logic [2:0] NRM_LD_U  = 3'd2;
  localparam logic [2:0] NRM_LD_CR = 3'd3;
  localparam logic [2:0] NRM_SCAN  = 3'd4;

  // multiplier operand sources
  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_NRM  = 3'd1;
  localparam logic [2:0] SRC_VW   = 3'd2;
  localparam logic [2:0] SRC_RT   = 3'd3;
  localparam logic [2:0] SRC_UPP  = 3'd4;
  localparam logic [2:0] SRC_PQ   = 3'd5;
  localparam logic [2:0] SRC_PR   = 3'd6;

  // accumulator operations, applied in the cycle after the multiply
  localparam logic [2:0] ACC_NOP     = 3'd0;
  localparam logic [2:0] ACC_LD      = 3'd1;
  localparam logic [2:0] ACC_ADD     = 3'd2;
  localparam logic [2:0] ACC_SUB_CR  = 3'd3;
  localparam logic [2:0] ACC_SUB_UPP = 3'd4;
  localparam logic [2:0] ACC2_LD     = 3'd5;
  localparam logic [2:0] ACC2_ADD    = 3'd6;
  localparam logic [2:0] ACC2_TR     = 3'd7;

  typedef struct packed {
    logic [2:0] nrm_op;
    logic       sqrt_go;
    logic       div_go;
    logic [1:0] div_idx;
    logic       div_rt;
    logic [2:0] src_a;
    logic [1:0] idx_a;
    logic [2:0] src_b;
    logic [1:0] idx_b;
    logic [2:0] acc_op;
    logic [1:0] wr_idx;
    logic       commit;
    logic [1:0] row;
  } lav_cmd_t;

  typedef struct packed {
    logic nrm_zero;
    logic nrm_ok;
    logic sqrt_done;
    logic div_done;
  } lav_sts_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[OUT_W-1:0];
    else if (v < lo) return lo[OUT_W-1:0];
    else return v[OUT_W-1:0];
  endfunction

  // shift right by FRAC_BITS, round to nearest, ties away from zero
  function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] m;
    m = x[ACC_W-1] ? (~x + 64'd1) : x;
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[ACC_W-1] ? signed'(~m + 64'd1) : signed'(m);
  endfunction

endpackage

### rtl/look_at_view_matrix.sv
// Top level of the fixed-point look-at view matrix block.
//
// Input channel (in_valid / in_stall): one word carries camera position,
// target and up hint, nine signed Q16.16 values. A word is taken when
// in_valid is high and in_stall is low; in_stall stays high from the
// accepted word until its last result row has been taken.
// Result channel (out_valid / out_stall): three words per input, rows
// right, up and view in that order, each with the translation -(axis . P).
// out_last_row marks the view row; out_degenerate marks a repeat of the
// previously stored matrix (position equal to target, up hint zero, or up parallel to view).
// Processing: each of the three scaling passes (view, up hint, cross) shifts
// one bit per scan step; each normalization then runs the 32-step square
// root and three 18-step divisions, and all products go through one shared
// multiplier. A degenerate input answers as soon as a scan finds a zero
// vector. Rows then leave one per cycle while out_stall is low; the next word
// is taken the cycle after the last row.
// A stalled result row holds its value until taken; the block waits.
// Reset (synchronous, rst_n low) returns to idle and loads the identity.
module look_at_view_matrix import lav_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_pos_x,
  input  logic signed [FIELD_W-1:0] in_pos_y,
  input  logic signed [FIELD_W-1:0] in_pos_z,
  input  logic signed [FIELD_W-1:0] in_target_x,
  input  logic signed [FIELD_W-1:0] in_target_y,
  input  logic signed [FIELD_W-1:0] in_target_z,
  input  logic signed [FIELD_W-1:0] in_upvec_x,
  input  logic signed [FIELD_W-1:0] in_upvec_y,
  input  logic signed [FIELD_W-1:0] in_upvec_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_row_index,
  output logic signed [FIELD_W-1:0] out_col0,
  output logic signed [FIELD_W-1:0] out_col1,
  output logic signed [FIELD_W-1:0] out_col2,
  output logic signed [FIELD_W-1:0] out_translation,
  output logic                      out_last_row,
  output logic                      out_degenerate
);

  lav_cmd_t cmd;
  lav_sts_t sts;

  // sequencer: owns both handshakes and the row counter
  lav_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_index  (out_row_index),
    .out_last_row   (out_last_row),
    .out_degenerate (out_degenerate),
    .cmd            (cmd),
    .sts            (sts)
  );

  // arithmetic and kept matrix; the row columns come straight from the store
  lav_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .in_target_z (in_target_z),
    .in_upvec_x  (in_upvec_x),
    .in_upvec_y  (in_upvec_y),
    .in_upvec_z  (in_upvec_z),
    .col0        (out_col0),
    .col1        (out_col1),
    .col2        (out_col2),
    .translation (out_translation)
  );

endmodule

### rtl/lav_ctrl.sv
// Sequencer of the look-at block: steps the shared datapath through one item.
module lav_ctrl import lav_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_row_index,
  output logic       out_last_row,
  output logic       out_degenerate,
  output lav_cmd_t   cmd,
  input  lav_sts_t   sts
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCAN  = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_CROSS = 4'd5;
  localparam logic [3:0] ST_UPP   = 4'd6;
  localparam logic [3:0] ST_DOT   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  localparam logic [1:0] PH_VIEW = 2'd0;
  localparam logic [1:0] PH_UP   = 2'd1;
  localparam logic [1:0] PH_CR   = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] div_i_r, div_i_nxt;
  logic [1:0] row_r, row_nxt;
  logic       degen_r, degen_nxt;
  logic [1:0] c_first, c_second;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_EMIT);
  assign out_row_index  = row_r;
  assign out_last_row   = (row_r == 2'd2);
  assign out_degenerate = degen_r;

  // operand pairs of one cross product component
  always_comb begin
    case (cnt_r[2:1])
      2'd0: begin c_first = 2'd1; c_second = 2'd2; end
      2'd1: begin c_first = 2'd2; c_second = 2'd0; end
      2'd2: begin c_first = 2'd0; c_second = 2'd1; end
      default: begin c_first = 2'd0; c_second = 2'd0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    div_i_nxt = div_i_r;
    row_nxt   = row_r;
    degen_nxt = degen_r;
    cmd       = '0;
    cmd.row   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.nrm_op = NRM_LD_D;
          phase_nxt  = PH_VIEW;
          degen_nxt  = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.nrm_op = NRM_SCAN;
        if (sts.nrm_zero) begin
          degen_nxt = 1'b1;
          row_nxt   = 2'd0;
          state_nxt = ST_EMIT;
        end else if (sts.nrm_ok) begin
          cnt_nxt   = 3'd0;
          state_nxt = (phase_r == PH_UP) ? ST_CROSS : ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_r != 3'd3) begin
          cmd.src_a  = SRC_NRM;
          cmd.idx_a  = cnt_r[1:0];
          cmd.src_b  = SRC_NRM;
          cmd.idx_b  = cnt_r[1:0];
          cmd.acc_op = (cnt_r == 3'd0) ? ACC_LD : ACC_ADD;
          cnt_nxt    = cnt_r + 3'd1;
        end else begin
          cnt_nxt   = 3'd0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == 3'd0) begin
          cmd.sqrt_go = 1'b1;
          cnt_nxt     = 3'd1;
        end else if (sts.sqrt_done) begin
          cnt_nxt   = 3'd0;
          div_i_nxt = 2'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == 3'd0) begin
          cmd.div_go  = 1'b1;
          cmd.div_idx = div_i_r;
          cmd.div_rt  = (phase_r == PH_CR);
          cnt_nxt     = 3'd1;
        end else if (sts.div_done) begin
          cnt_nxt = 3'd0;
          if (div_i_r != 2'd2) begin
            div_i_nxt = div_i_r + 2'd1;
          end else if (phase_r == PH_VIEW) begin
            cmd.nrm_op = NRM_LD_U;
            phase_nxt  = PH_UP;
            state_nxt  = ST_SCAN;
          end else begin
            state_nxt = ST_UPP;
          end
        end
      end
      ST_CROSS, ST_UPP: begin
        if (cnt_r < 3'd6) begin
          cmd.src_a  = (state_r == ST_CROSS) ? SRC_NRM : SRC_VW;
          cmd.src_b  = (state_r == ST_CROSS) ? SRC_VW : SRC_RT;
          cmd.idx_a  = cnt_r[0] ? c_second : c_first;
          cmd.idx_b  = cnt_r[0] ? c_first : c_second;
          cmd.wr_idx = cnt_r[2:1];
          if (!cnt_r[0]) cmd.acc_op = ACC_LD;
          else cmd.acc_op = (state_r == ST_CROSS) ? ACC_SUB_CR : ACC_SUB_UPP;
          cnt_nxt = cnt_r + 3'd1;
        end else if (cnt_r == 3'd6) begin
          cnt_nxt = 3'd7;
        end else begin
          cnt_nxt = 3'd0;
          if (state_r == ST_CROSS) begin
            cmd.nrm_op = NRM_LD_CR;
            phase_nxt  = PH_CR;
            state_nxt  = ST_SCAN;
          end else begin
            cmd.commit = 1'b1;
            row_nxt    = 2'd0;
            state_nxt  = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (cnt_r < 3'd6) begin
          case (row_r)
            2'd0:    cmd.src_a = SRC_RT;
            2'd1:    cmd.src_a = SRC_UPP;
            default: cmd.src_a = SRC_VW;
          endcase
          cmd.idx_a  = cnt_r[2:1];
          cmd.idx_b  = cnt_r[2:1];
          cmd.src_b  = cnt_r[0] ? SRC_PR : SRC_PQ;
          cmd.wr_idx = row_r;
          case (cnt_r)
            3'd0:    cmd.acc_op = ACC_LD;
            3'd1:    cmd.acc_op = ACC2_LD;
            3'd5:    cmd.acc_op = ACC2_TR;
            default: cmd.acc_op = cnt_r[0] ? ACC2_ADD : ACC_ADD;
          endcase
          if (cnt_r == 3'd5) begin
            if (row_r == 2'd2) begin
              cnt_nxt = 3'd6;
            end else begin
              cnt_nxt = 3'd0;
              row_nxt = row_r + 2'd1;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end else begin
          cnt_nxt   = 3'd0;
          row_nxt   = 2'd0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (row_r == 2'd2) begin
            row_nxt   = 2'd0;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 3'd0;
      phase_r <= PH_VIEW;
      div_i_r <= 2'd0;
      row_r   <= 2'd0;
      degen_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      div_i_r <= div_i_nxt;
      row_r   <= row_nxt;
      degen_r <= degen_nxt;
    end
  end

endmodule

### rtl/lav_dp.sv
// Datapath of the look-at block: shared multiplier, square root, divider and matrix store.
module lav_dp import lav_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lav_cmd_t                  cmd,
  output lav_sts_t                  sts,
  input  logic signed [FIELD_W-1:0] in_pos_x,
  input  logic signed [FIELD_W-1:0] in_pos_y,
  input  logic signed [FIELD_W-1:0] in_pos_z,
  input  logic signed [FIELD_W-1:0] in_target_x,
  input  logic signed [FIELD_W-1:0] in_target_y,
  input  logic signed [FIELD_W-1:0] in_target_z,
  input  logic signed [FIELD_W-1:0] in_upvec_x,
  input  logic signed [FIELD_W-1:0] in_upvec_y,
  input  logic signed [FIELD_W-1:0] in_upvec_z,
  output logic signed [FIELD_W-1:0] col0,
  output logic signed [FIELD_W-1:0] col1,
  output logic signed [FIELD_W-1:0] col2,
  output logic signed [FIELD_W-1:0] translation
);

  logic signed [FIELD_W-1:0] pin [3];
  logic signed [FIELD_W-1:0] tin [3];
  logic signed [FIELD_W-1:0] uin [3];
  logic signed [FIELD_W-1:0] p_r [3];
  logic signed [FIELD_W-1:0] u_r [3];

  logic [NRM_W-1:0] nrm_mag_r [3];
  logic             nrm_neg_r [3];
  logic [NRM_W-1:0] cr_mag_r [3];
  logic             cr_neg_r [3];
  logic signed [VEC_W-1:0] vw_r [3];
  logic signed [VEC_W-1:0] rt_r [3];
  logic signed [VEC_W-1:0] upp_r [3];

  logic signed [OUT_W-1:0] km_r [3][3];
  logic signed [OUT_W-1:0] kt_r [3];

  logic signed [FIELD_W:0] dsum [3];
  logic [FIELD_W:0]        dmag [3];
  logic [FIELD_W-1:0]      umag [3];
  logic [2:0] hi_bits, top_bits, nz_bits;

  logic signed [MUL_W-1:0] opa, opb;
  logic signed [ACC_W-1:0] prod_r, acc_r, acc2_r;
  logic [2:0]              aop_r;
  logic [1:0]              wr_r;
  logic signed [ACC_W-1:0] diff, tsum;
  logic [ACC_W-1:0]        dmag64;

  logic [ACC_W-1:0] sq_n_r, sq_res_r, sq_bit_r, sq_trial;
  logic [4:0]       sq_cnt_r;
  logic             sq_busy_r, sq_done_r;

  logic [DIVN_W-1:0]      divn;
  logic [REM_W-1:0]       dv_rem_r, dv_t, dv_d;
  logic [QB-1:0]          dv_low_r, dv_q_r, dv_qn;
  logic [QCNT_W-1:0]      dv_cnt_r;
  logic                   dv_busy_r, dv_done_r, dv_rt_r, dv_neg_r, dv_ge;
  logic [1:0]             dv_idx_r;
  logic signed [VEC_W-1:0] dv_qv;

  assign pin[0] = in_pos_x;    assign pin[1] = in_pos_y;    assign pin[2] = in_pos_z;
  assign tin[0] = in_target_x; assign tin[1] = in_target_y; assign tin[2] = in_target_z;
  assign uin[0] = in_upvec_x;  assign uin[1] = in_upvec_y;  assign uin[2] = in_upvec_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i]     = {pin[i][FIELD_W-1], pin[i]} - {tin[i][FIELD_W-1], tin[i]};
      dmag[i]     = dsum[i][FIELD_W] ? (~dsum[i] + 1'b1) : dsum[i];
      umag[i]     = u_r[i][FIELD_W-1] ? (~u_r[i] + 1'b1) : u_r[i];
      hi_bits[i]  = |nrm_mag_r[i][NRM_W-1:30];
      top_bits[i] = |nrm_mag_r[i][NRM_W-1:29];
      nz_bits[i]  = |nrm_mag_r[i];
    end
  end

  assign sts.nrm_zero  = ~|nz_bits;
  assign sts.nrm_ok    = ~|hi_bits & |top_bits;
  assign sts.sqrt_done = sq_done_r;
  assign sts.div_done  = dv_done_r;

  // load and scale: one bit per scan cycle until the largest magnitude lies in [2^29, 2^30)
  always_ff @(posedge clk) begin
    case (cmd.nrm_op)
      NRM_LD_D: begin
        for (int i = 0; i < 3; i++) begin
          nrm_mag_r[i] <= NRM_W'(dmag[i]);
          nrm_neg_r[i] <= dsum[i][FIELD_W];
          p_r[i]       <= pin[i];
          u_r[i]       <= uin[i];
        end
      end
      NRM_LD_U: begin
        for (int i = 0; i < 3; i++) begin
          nrm_mag_r[i] <= NRM_W'(umag[i]);
          nrm_neg_r[i] <= u_r[i][FIELD_W-1];
        end
      end
      NRM_LD_CR: begin
        for (int i = 0; i < 3; i++) begin
          nrm_mag_r[i] <= cr_mag_r[i];
          nrm_neg_r[i] <= cr_neg_r[i];
        end
      end
      NRM_SCAN: begin
        if (!sts.nrm_zero && !sts.nrm_ok) begin
          for (int i = 0; i < 3; i++) begin
            nrm_mag_r[i] <= (|hi_bits) ? (nrm_mag_r[i] >> 1) : (nrm_mag_r[i] << 1);
          end
        end
      end
      default: ;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.src_a)
      SRC_NRM: opa = nrm_neg_r[cmd.idx_a] ? -signed'({1'b0, nrm_mag_r[cmd.idx_a][30:0]})
                                          : signed'({1'b0, nrm_mag_r[cmd.idx_a][30:0]});
      SRC_VW:  opa = MUL_W'(vw_r[cmd.idx_a]);
      SRC_RT:  opa = MUL_W'(rt_r[cmd.idx_a]);
      SRC_UPP: opa = MUL_W'(upp_r[cmd.idx_a]);
      default: opa = '0;
    endcase
    case (cmd.src_b)
      SRC_VW:  opb = MUL_W'(vw_r[cmd.idx_b]);
      SRC_RT:  opb = MUL_W'(rt_r[cmd.idx_b]);
      SRC_NRM: opb = nrm_neg_r[cmd.idx_b] ? -signed'({1'b0, nrm_mag_r[cmd.idx_b][30:0]})
                                          : signed'({1'b0, nrm_mag_r[cmd.idx_b][30:0]});
      SRC_PQ:  opb = p_r[cmd.idx_b] >>> FRAC_BITS;
      SRC_PR:  opb = signed'({{(MUL_W-FRAC_BITS){1'b0}}, p_r[cmd.idx_b][FRAC_BITS-1:0]});
      default: opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    wr_r   <= cmd.wr_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) aop_r <= ACC_NOP;
    else aop_r <= cmd.acc_op;
  end

  always_comb begin
    diff   = acc_r - prod_r;
    dmag64 = diff[ACC_W-1] ? (~diff + 64'd1) : diff;
    tsum   = acc_r + round_frac(acc2_r + prod_r);
  end

  always_ff @(posedge clk) begin
    case (aop_r)
      ACC_LD:      acc_r <= prod_r;
      ACC_ADD:     acc_r <= acc_r + prod_r;
      ACC_SUB_CR: begin
        cr_mag_r[wr_r] <= NRM_W'(dmag64);
        cr_neg_r[wr_r] <= diff[ACC_W-1];
      end
      ACC_SUB_UPP: upp_r[wr_r] <= VEC_W'(round_frac(diff));
      ACC2_LD:     acc2_r <= prod_r;
      ACC2_ADD:    acc2_r <= acc2_r + prod_r;
      default: ;
    endcase
  end

  // integer square root, one result bit per step, 32 steps
  assign sq_trial = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_go) begin
      sq_n_r   <= acc_r;
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
      sq_cnt_r <= '0;
    end else if (sq_busy_r) begin
      if (sq_n_r >= sq_trial) begin
        sq_n_r   <= sq_n_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
      sq_cnt_r <= sq_cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
    end else if (cmd.sqrt_go) begin
      sq_busy_r <= 1'b1;
      sq_done_r <= 1'b0;
    end else if (sq_busy_r && sq_cnt_r == 5'd31) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b1;
    end
  end

  // restoring divider: (e * 2^(F+1) + r) / (2r), one quotient bit per cycle
  always_comb begin
    divn  = (DIVN_W'(nrm_mag_r[cmd.div_idx][29:0]) << (FRAC_BITS + 1))
            + DIVN_W'(sq_res_r[31:0]);
    dv_d  = REM_W'({sq_res_r[31:0], 1'b0});
    dv_t  = {dv_rem_r[REM_W-2:0], dv_low_r[QB-1]};
    dv_ge = (dv_t >= dv_d);
    dv_qn = {dv_q_r[QB-2:0], dv_ge};
    dv_qv = signed'(VEC_W'(dv_qn));
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dv_rem_r <= REM_W'(divn >> QB);
      dv_low_r <= divn[QB-1:0];
      dv_q_r   <= '0;
      dv_cnt_r <= '0;
      dv_idx_r <= cmd.div_idx;
      dv_rt_r  <= cmd.div_rt;
      dv_neg_r <= nrm_neg_r[cmd.div_idx];
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? (dv_t - dv_d) : dv_t;
      dv_low_r <= dv_low_r << 1;
      dv_q_r   <= dv_qn;
      dv_cnt_r <= dv_cnt_r + 1'b1;
      if (dv_cnt_r == QCNT_W'(QB - 1)) begin
        if (dv_rt_r) rt_r[dv_idx_r] <= dv_neg_r ? -dv_qv : dv_qv;
        else vw_r[dv_idx_r] <= dv_neg_r ? -dv_qv : dv_qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_done_r <= 1'b0;
    end else if (cmd.div_go) begin
      dv_busy_r <= 1'b1;
      dv_done_r <= 1'b0;
    end else if (dv_busy_r && dv_cnt_r == QCNT_W'(QB - 1)) begin
      dv_busy_r <= 1'b0;
      dv_done_r <= 1'b1;
    end
  end

  // kept matrix: identity after reset, replaced only by a full good item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          km_r[k][i] <= (k == i) ? sat_out(64'sd1 <<< FRAC_BITS) : '0;
        end
        kt_r[k] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        for (int i = 0; i < 3; i++) begin
          km_r[0][i] <= sat_out(ACC_W'(rt_r[i]));
          km_r[1][i] <= sat_out(ACC_W'(upp_r[i]));
          km_r[2][i] <= sat_out(ACC_W'(vw_r[i]));
        end
      end
      if (aop_r == ACC2_TR) kt_r[wr_r] <= sat_out(-tsum);
    end
  end

  assign col0        = FIELD_W'(km_r[cmd.row][0]);
  assign col1        = FIELD_W'(km_r[cmd.row][1]);
  assign col2        = FIELD_W'(km_r[cmd.row][2]);
  assign translation = FIELD_W'(kt_r[cmd.row]);

endmodule

### rtl/lav_chk.sv
// Port-level checker of the look-at block and its bind to the top level.
module lav_chk import lav_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_row_index,
  input logic signed [FIELD_W-1:0] out_col0,
  input logic                      out_last_row,
  input logic                      out_degenerate
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_col0))
    else $error("stalled result word dropped or changed");

  // no new input while rows of the previous one are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // rows follow back to back in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_row |=>
      out_valid && out_row_index == $past(out_row_index) + 2'd1)
    else $error("result rows out of order");

  // last-row flag marks the view row only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == 2'd2)))
    else $error("last-row flag mismatch");

  // degenerate flag is constant across the rows of one matrix
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_row |=> $stable(out_degenerate))
    else $error("degenerate flag changed within a matrix");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_row_index  (out_row_index),
  .out_col0       (out_col0),
  .out_last_row   (out_last_row),
  .out_degenerate (out_degenerate)
);

### test/tb_top.sv
// Testbench for the look-at view matrix block, with a scoreboard and random traffic.
`timescale 1ns / 100ps

module tb_top;
  import lav_pkg::*;

  localparam int LIMIT = 400000;

  typedef longint vec3_t [3];

  // One expected matrix row: the fields of one result word.
  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] tr;
    logic        last;
    logic        degen;
  } mat_row_t;

  // Keep a private copy of the stored matrix and queue the rows each camera
  // setup should produce.
  class view_matrix_board;
    longint   kept[12];
    mat_row_t rows_due[$];
    int       errors;

    function new();
      errors = 0;
      foreach (kept[i]) kept[i] = 0;
      for (int i = 0; i < 3; i++) kept[i * 4 + i] = sat(64'sd1 <<< FRAC_BITS);
    endfunction

    function longint sat(longint v);
      longint hi;
      hi = (64'sd1 <<< (OUT_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint absv(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Round away the fraction bits, ties away from zero.
    function longint rnd(longint x);
      longint m;
      m = (absv(x) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (x < 0) ? -m : m;
    endfunction

    function longint isqrt(longint n);
      longint res, b;
      res = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >>> 1) + b;
        end else res = res >>> 1;
        b = b >>> 2;
      end
      return res;
    endfunction

    // Bring the largest magnitude into [2^29, 2^30); report an all-zero vector.
    function bit scale(input vec3_t v, output vec3_t o);
      longint mx, m;
      int dn, up;
      mx = 0;
      dn = 0;
      up = 0;
      for (int i = 0; i < 3; i++) if (absv(v[i]) > mx) mx = absv(v[i]);
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (mx == 0) return 0;
      while (mx >= (64'sd1 <<< 30)) begin
        mx = mx >>> 1;
        dn++;
      end
      while (mx < (64'sd1 <<< 29)) begin
        mx = mx <<< 1;
        up++;
      end
      for (int i = 0; i < 3; i++) begin
        m = (absv(v[i]) >>> dn) <<< up;
        o[i] = (v[i] < 0) ? -m : m;
      end
      return 1;
    endfunction

    function bit unit_vec(input vec3_t v, output vec3_t o);
      vec3_t e;
      longint s, r, q;
      s = 0;
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (!scale(v, e)) return 0;
      for (int i = 0; i < 3; i++) s += e[i] * e[i];
      r = isqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = ((absv(e[i]) <<< FRAC_BITS) * 2 + r) / (2 * r);
        o[i] = (e[i] < 0) ? -q : q;
      end
      return 1;
    endfunction

    // Exact dot with the position, split into whole and fraction parts.
    function longint neg_dot(vec3_t a, vec3_t p);
      longint whole, part;
      whole = 0;
      part = 0;
      for (int i = 0; i < 3; i++) begin
        whole += a[i] * (p[i] >>> FRAC_BITS);
        part += a[i] * (p[i] & ((64'sd1 <<< FRAC_BITS) - 1));
      end
      return sat(-(whole + rnd(part)));
    endfunction

    // Note one accepted camera setup and queue its three rows.
    function void note_setup(logic signed [31:0] f[9]);
      vec3_t p, d, u, us, vw, cr, rt, upp;
      bit degen;
      mat_row_t r;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'(f[i]);
        d[i] = longint'(f[i]) - longint'(f[3 + i]);
        u[i] = longint'(f[6 + i]);
      end
      degen = !unit_vec(d, vw);
      if (!degen) begin
        void'(scale(u, us));
        cr[0] = us[1] * vw[2] - us[2] * vw[1];
        cr[1] = us[2] * vw[0] - us[0] * vw[2];
        cr[2] = us[0] * vw[1] - us[1] * vw[0];
        degen = !unit_vec(cr, rt);
      end
      if (!degen) begin
        upp[0] = rnd(vw[1] * rt[2] - vw[2] * rt[1]);
        upp[1] = rnd(vw[2] * rt[0] - vw[0] * rt[2]);
        upp[2] = rnd(vw[0] * rt[1] - vw[1] * rt[0]);
        for (int i = 0; i < 3; i++) begin
          kept[i] = sat(rt[i]);
          kept[4 + i] = sat(upp[i]);
          kept[8 + i] = sat(vw[i]);
        end
        kept[3] = neg_dot(rt, p);
        kept[7] = neg_dot(upp, p);
        kept[11] = neg_dot(vw, p);
      end
      for (int k = 0; k < 3; k++) begin
        r.row = 2'(k);
        r.c0 = 32'(kept[k * 4]);
        r.c1 = 32'(kept[k * 4 + 1]);
        r.c2 = 32'(kept[k * 4 + 2]);
        r.tr = 32'(kept[k * 4 + 3]);
        r.last = (k == 2);
        r.degen = degen;
        rows_due.push_back(r);
      end
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    // Check one taken row against the oldest expectation.
    function void check_row(mat_row_t got);
      mat_row_t w;
      if (rows_due.size() == 0) begin
        $error("row with no expectation pending: row_index %0d", got.row);
        errors++;
        return;
      end
      w = rows_due.pop_front();
      cmp("row_index", 32'(w.row), 32'(got.row));
      cmp("col0", w.c0, got.c0);
      cmp("col1", w.c1, got.c1);
      cmp("col2", w.c2, got.c2);
      cmp("translation", w.tr, got.tr);
      cmp("last_row", 32'(w.last), 32'(got.last));
      cmp("degenerate", 32'(w.degen), 32'(got.degen));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_f[9];
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col0, out_col1, out_col2, out_translation;
  logic out_last_row, out_degenerate;
  int cycles = 0;
  bit stall_quiet = 0;
  int stall_left = 0;
  view_matrix_board board;

  initial foreach (in_f[i]) in_f[i] = 0;

  always #5 clk = ~clk;

  look_at_view_matrix u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_f[0]), .in_pos_y(in_f[1]), .in_pos_z(in_f[2]),
    .in_target_x(in_f[3]), .in_target_y(in_f[4]), .in_target_z(in_f[5]),
    .in_upvec_x(in_f[6]), .in_upvec_y(in_f[7]), .in_upvec_z(in_f[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row_index(out_row_index), .out_col0(out_col0), .out_col1(out_col1),
    .out_col2(out_col2), .out_translation(out_translation),
    .out_last_row(out_last_row), .out_degenerate(out_degenerate)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Throttle the result side: runs of stall or no stall, mostly short,
  // occasionally long; a quiet window disables stalls entirely.
  always @(posedge clk) begin
    if (stall_left > 0) stall_left <= stall_left - 1;
    else begin
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(15, 50);
      out_stall <= !stall_quiet && ($urandom_range(0, 2) == 0);
    end
  end

  // Take each accepted result word and hand it to the scoreboard.
  always @(posedge clk) begin
    mat_row_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.row = out_row_index;
      got.c0 = out_col0;
      got.c1 = out_col1;
      got.c2 = out_col2;
      got.tr = out_translation;
      got.last = out_last_row;
      got.degen = out_degenerate;
      board.check_row(got);
    end
  end

  // Drive one camera setup and hold it until the block takes it, then
  // optionally drop valid for a random gap.
  task automatic send_setup(logic signed [31:0] f[9]);
    int gap;
    for (int i = 0; i < 9; i++) in_f[i] <= f[i];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_setup(f);
    gap = ($urandom_range(0, 9) < 5) ? 0 :
          (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_vecs(longint p[3], longint t[3], longint u[3]);
    logic signed [31:0] f[9];
    for (int i = 0; i < 3; i++) begin
      f[i] = 32'(p[i]);
      f[3 + i] = 32'(t[i]);
      f[6 + i] = 32'(u[i]);
    end
    send_setup(f);
  endtask

  // Random value, often narrowed so that scaling sees many magnitudes.
  function automatic logic signed [31:0] rand_word();
    logic signed [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 2) == 0) w = w >>> $urandom_range(1, 30);
    return w;
  endfunction

  task automatic send_random();
    logic signed [31:0] f[9];
    int kind;
    foreach (f[i]) f[i] = rand_word();
    kind = $urandom_range(0, 11);
    // position equal to target
    if (kind == 0) for (int i = 0; i < 3; i++) f[3 + i] = f[i];
    // up hint zero
    else if (kind == 1) for (int i = 0; i < 3; i++) f[6 + i] = 0;
    // up hint parallel to the view direction, either sense
    else if (kind == 2) begin
      for (int i = 0; i < 3; i++) begin
        f[i] = f[i] >>> 2;
        f[3 + i] = f[3 + i] >>> 2;
        f[6 + i] = ($urandom_range(0, 1)) ? f[i] - f[3 + i] : f[3 + i] - f[i];
      end
    end
    send_setup(f);
  endtask

  localparam longint MAXW = 64'sd2147483647;
  localparam longint MINW = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: degenerate first, so the reset identity comes back.
    send_vecs('{0, 0, 0}, '{0, 0, 0}, '{0, ONE, 0});
    send_vecs('{ONE, 2 * ONE, 3 * ONE}, '{ONE, 2 * ONE, 3 * ONE}, '{0, ONE, 0});
    send_vecs('{0, 0, 5 * ONE}, '{0, 0, 0}, '{0, ONE, 0});
    send_vecs('{3 * ONE, 4 * ONE, 5 * ONE}, '{0, 0, 0}, '{0, ONE, 0});
    // up zero and up parallel repeat the last matrix
    send_vecs('{ONE, ONE, ONE}, '{0, 0, 0}, '{0, 0, 0});
    send_vecs('{0, 2 * ONE, 0}, '{0, 0, 0}, '{0, 7 * ONE, 0});
    send_vecs('{0, 2 * ONE, 0}, '{0, 0, 0}, '{0, -ONE, 0});
    // extreme differences that need the full 33 bits
    send_vecs('{MAXW, MAXW, MAXW}, '{MINW, MINW, MINW}, '{MINW, MAXW, 0});
    send_vecs('{MINW, MINW, MINW}, '{MAXW, MAXW, MAXW}, '{MAXW, MINW, MAXW});
    send_vecs('{MAXW, MINW, 0}, '{MINW, MAXW, 0}, '{0, 0, MAXW});
    send_vecs('{MAXW, 0, 0}, '{MAXW - 1, 0, 0}, '{0, 1, 0});
    send_vecs('{MINW, 0, 1}, '{MINW, 0, 0}, '{MINW, MINW, MINW});
    send_vecs('{-1, -1, -1}, '{1, 1, 1}, '{-1, 1, 0});
    send_vecs('{5 * ONE, -7 * ONE, ONE / 2}, '{-ONE, ONE, 0}, '{ONE, ONE, -ONE});

    // Random setups; halfway, hold the sender until the block has drained,
    // and run a stretch with no result stalls.
    for (int n = 0; n < 100; n++) begin
      if (n == 50) begin
        in_valid <= 0;
        while (board.rows_due.size() != 0) @(posedge clk);
      end
      stall_quiet = (n >= 60 && n < 75);
      send_random();
    end
    in_valid <= 0;

    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
